// ===== hw/rtl/plrs_pkg.sv =====
// Shared types and constants for the pixel line replication scaler.
`default_nettype none
package plrs_pkg;

  localparam int DEF_MAX_SOURCE_SIZE = 4096;
  localparam int DEF_MAX_TARGET_SIZE = 65535;

  localparam int PIXEL_W     = 24;
  localparam int COUNT_OUT_W = 16;
  localparam int SRC_REG_W   = 13;
  localparam int DST_REG_W   = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_TARGET_WIDTH  = 3'd1,
    REG_SOURCE_HEIGHT = 3'd2,
    REG_TARGET_HEIGHT = 3'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_EVEN   = 2'd0,
    MODE_ON_MUL = 2'd1,
    MODE_OFF_MUL = 2'd2
  } mode_t;

  typedef struct packed {
    logic restart;
    logic busy;
  } cfg_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/plrs_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module plrs_div #(
  parameter int W = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quotient,
  output logic [W-1:0]      remainder
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  assign trial = {rem, quo[W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = ~diff[W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[W-1:0] : trial[W-1:0];
      quo <= {quo[W-2:0], ge};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule
`default_nettype wire

// ===== hw/rtl/plrs_cfg.sv =====
// Size registers and derivation of base counts, periods and modes per axis.
`default_nettype none
module plrs_cfg #(
  parameter int MAX_SOURCE_SIZE = plrs_pkg::DEF_MAX_SOURCE_SIZE,
  parameter int MAX_TARGET_SIZE = plrs_pkg::DEF_MAX_TARGET_SIZE,
  parameter int SW = $clog2(MAX_SOURCE_SIZE + 1),
  parameter int TW = $clog2(MAX_TARGET_SIZE + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [plrs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [plrs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output plrs_pkg::cfg_stat_t                    stat,
  output logic [SW-1:0]                          h_src,
  output logic [TW-1:0]                          h_dst,
  output logic [TW-1:0]                          h_base,
  output logic [SW-1:0]                          h_period,
  output plrs_pkg::mode_t                        h_mode,
  output logic [SW-1:0]                          v_src,
  output logic [TW-1:0]                          v_dst,
  output logic [TW-1:0]                          v_base,
  output logic [SW-1:0]                          v_period,
  output plrs_pkg::mode_t                        v_mode
);
  import plrs_pkg::*;

  localparam int DW = (TW > SW) ? TW : SW;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_HBASE = 5'b00010,
    ST_HPER  = 5'b00100,
    ST_VBASE = 5'b01000,
    ST_VPER  = 5'b10000
  } state_t;

  state_t              state;
  logic [SRC_REG_W-1:0] source_width;
  logic [DST_REG_W-1:0] target_width;
  logic [SRC_REG_W-1:0] source_height;
  logic [DST_REG_W-1:0] target_height;
  logic [SW-1:0]        rem_r;
  logic                 div_start;
  logic                 div_done;
  logic [DW-1:0]        dividend;
  logic [DW-1:0]        divisor;
  logic [DW-1:0]        div_q;
  logic [DW-1:0]        div_r;
  logic                 wr;
  logic                 wr_known;
  logic                 zero_rem;
  logic                 on_mul;
  logic [DW:0]          cur_src;

  function automatic logic [SW-1:0] eff_src(input logic [SRC_REG_W-1:0] v);
    logic [SW-1:0] r;
    if (v == '0) r = SW'(1);
    else if (32'(v) > 32'(MAX_SOURCE_SIZE)) r = SW'(MAX_SOURCE_SIZE);
    else r = SW'(v);
    return r;
  endfunction

  function automatic logic [TW-1:0] eff_dst(input logic [DST_REG_W-1:0] v);
    logic [TW-1:0] r;
    if (v == '0) r = TW'(1);
    else if (32'(v) > 32'(MAX_TARGET_SIZE)) r = TW'(MAX_TARGET_SIZE);
    else r = TW'(v);
    return r;
  endfunction

  assign h_src = eff_src(source_width);
  assign h_dst = eff_dst(target_width);
  assign v_src = eff_src(source_height);
  assign v_dst = eff_dst(target_height);

  assign cfg_ready = (state == ST_IDLE);
  assign wr        = cfg_valid & cfg_ready;

  always_comb begin
    case (cfg_index)
      REG_SOURCE_WIDTH, REG_TARGET_WIDTH,
      REG_SOURCE_HEIGHT, REG_TARGET_HEIGHT: wr_known = 1'b1;
      default: wr_known = 1'b0;
    endcase
  end

  assign stat = '{restart: wr & wr_known, busy: (state != ST_IDLE)};

  always_comb begin
    case (state)
      ST_HBASE: begin
        dividend = DW'(h_dst);
        divisor  = DW'(h_src);
      end
      ST_HPER: begin
        dividend = DW'(h_src);
        divisor  = (h_mode == MODE_ON_MUL) ? DW'(rem_r) : DW'(h_src - rem_r);
      end
      ST_VBASE: begin
        dividend = DW'(v_dst);
        divisor  = DW'(v_src);
      end
      ST_VPER: begin
        dividend = DW'(v_src);
        divisor  = (v_mode == MODE_ON_MUL) ? DW'(rem_r) : DW'(v_src - rem_r);
      end
      default: begin
        dividend = '0;
        divisor  = DW'(1);
      end
    endcase
  end

  plrs_div #(.W(DW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (dividend),
    .divisor   (divisor),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign zero_rem = (div_r == '0);
  assign cur_src  = (state == ST_HBASE) ? (DW+1)'(h_src) : (DW+1)'(v_src);
  assign on_mul   = ({1'b0, div_r} << 1) <= cur_src;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      div_start     <= 1'b0;
      source_width  <= SRC_REG_W'(1);
      target_width  <= DST_REG_W'(1);
      source_height <= SRC_REG_W'(1);
      target_height <= DST_REG_W'(1);
      h_base        <= TW'(1);
      h_period      <= SW'(1);
      h_mode        <= MODE_EVEN;
      v_base        <= TW'(1);
      v_period      <= SW'(1);
      v_mode        <= MODE_EVEN;
    end else begin
      div_start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (wr) begin
            case (cfg_index)
              REG_SOURCE_WIDTH:  source_width  <= cfg_data[SRC_REG_W-1:0];
              REG_TARGET_WIDTH:  target_width  <= cfg_data[DST_REG_W-1:0];
              REG_SOURCE_HEIGHT: source_height <= cfg_data[SRC_REG_W-1:0];
              REG_TARGET_HEIGHT: target_height <= cfg_data[DST_REG_W-1:0];
              default: ;
            endcase
            if (wr_known) begin
              state     <= ST_HBASE;
              div_start <= 1'b1;
            end
          end
        end
        ST_HBASE: begin
          if (div_done) begin
            h_base    <= TW'(div_q);
            rem_r     <= SW'(div_r);
            div_start <= 1'b1;
            if (zero_rem) begin
              h_mode   <= MODE_EVEN;
              h_period <= SW'(1);
              state    <= ST_VBASE;
            end else begin
              h_mode <= on_mul ? MODE_ON_MUL : MODE_OFF_MUL;
              state  <= ST_HPER;
            end
          end
        end
        ST_HPER: begin
          if (div_done) begin
            h_period  <= SW'(div_q);
            state     <= ST_VBASE;
            div_start <= 1'b1;
          end
        end
        ST_VBASE: begin
          if (div_done) begin
            v_base <= TW'(div_q);
            rem_r  <= SW'(div_r);
            if (zero_rem) begin
              v_mode   <= MODE_EVEN;
              v_period <= SW'(1);
              state    <= ST_IDLE;
            end else begin
              v_mode    <= on_mul ? MODE_ON_MUL : MODE_OFF_MUL;
              state     <= ST_VPER;
              div_start <= 1'b1;
            end
          end
        end
        ST_VPER: begin
          if (div_done) begin
            v_period <= SW'(div_q);
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/plrs_axis.sv =====
// Position, phase and emitted counters of one axis with its copy count.
`default_nettype none
module plrs_axis #(
  parameter int SW = 13,
  parameter int TW = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            clear,
  input  wire logic            step,
  input  wire logic [SW-1:0]   src,
  input  wire logic [TW-1:0]   dst,
  input  wire logic [TW-1:0]   base,
  input  wire logic [SW-1:0]   period,
  input  wire plrs_pkg::mode_t mode,
  output logic                 last,
  output logic [TW-1:0]        copies
);
  import plrs_pkg::*;

  logic [SW-1:0] idx;
  logic [SW-1:0] phase;
  logic [TW-1:0] emitted;
  logic          hit;
  logic          extra;
  logic [TW-1:0] room;
  logic [TW:0]   n;

  assign last  = ((SW+1)'(idx) + (SW+1)'(1)) >= (SW+1)'(src);
  assign hit   = ((SW+1)'(phase) + (SW+1)'(1)) == (SW+1)'(period);
  assign extra = ((mode == MODE_ON_MUL) && hit) || ((mode == MODE_OFF_MUL) && !hit);
  assign room  = dst - emitted;
  assign n     = (TW+1)'(base) + (TW+1)'(extra);

  always_comb begin
    if (emitted >= dst) copies = '0;
    else if (last) copies = room;
    else if (n < (TW+1)'(room)) copies = TW'(n);
    else copies = room;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      idx     <= '0;
      phase   <= '0;
      emitted <= '0;
    end else if (step) begin
      if (last) begin
        idx     <= '0;
        phase   <= '0;
        emitted <= '0;
      end else begin
        idx     <= idx + 1'b1;
        phase   <= hit ? '0 : phase + 1'b1;
        emitted <= emitted + copies;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pixel_line_replication_scaler_unit.sv =====
// Top level of the pixel line replication scaler.
//
//  channel | handshake             | words
//  --------+-----------------------+------------------------------------------
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//  in      | in_valid / in_ready   | pixel
//  out     | out_valid / out_ready | pixel_out, pixel_copies, row_copies,
//          |                       | end_of_row, end_of_frame
//
// One pixel per cycle unless out stalls or a derivation runs; a word passes
// the input and then the output register. A size write starts up to four
// serial max(TW,SW)-bit divisions; in and cfg stay not ready until they finish.
// Reset leaves all sizes at 1 and needs no derivation pass.
// A stalled out word holds; one more pixel is taken into the input register.
`default_nettype none
module pixel_line_replication_scaler_unit #(
  parameter int MAX_SOURCE_SIZE = plrs_pkg::DEF_MAX_SOURCE_SIZE,
  parameter int MAX_TARGET_SIZE = plrs_pkg::DEF_MAX_TARGET_SIZE
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [plrs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [plrs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [plrs_pkg::PIXEL_W-1:0]      pixel,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [plrs_pkg::PIXEL_W-1:0]           pixel_out,
  output logic [plrs_pkg::COUNT_OUT_W-1:0]       pixel_copies,
  output logic [plrs_pkg::COUNT_OUT_W-1:0]       row_copies,
  output logic                                   end_of_row,
  output logic                                   end_of_frame
);
  import plrs_pkg::*;

  localparam int SW = $clog2(MAX_SOURCE_SIZE + 1);
  localparam int TW = $clog2(MAX_TARGET_SIZE + 1);

  cfg_stat_t     stat;
  logic [SW-1:0] h_src;
  logic [TW-1:0] h_dst;
  logic [TW-1:0] h_base;
  logic [SW-1:0] h_period;
  mode_t         h_mode;
  logic [SW-1:0] v_src;
  logic [TW-1:0] v_dst;
  logic [TW-1:0] v_base;
  logic [SW-1:0] v_period;
  mode_t         v_mode;
  logic          h_last;
  logic          v_last;
  logic [TW-1:0] h_copies;
  logic [TW-1:0] v_copies;

  logic               s1_valid;
  logic [PIXEL_W-1:0] s1_pixel;
  logic               adv;

  plrs_cfg #(
    .MAX_SOURCE_SIZE (MAX_SOURCE_SIZE),
    .MAX_TARGET_SIZE (MAX_TARGET_SIZE),
    .SW              (SW),
    .TW              (TW)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .h_src     (h_src),
    .h_dst     (h_dst),
    .h_base    (h_base),
    .h_period  (h_period),
    .h_mode    (h_mode),
    .v_src     (v_src),
    .v_dst     (v_dst),
    .v_base    (v_base),
    .v_period  (v_period),
    .v_mode    (v_mode)
  );

  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !stat.busy && (!s1_valid || adv);

  plrs_axis #(.SW(SW), .TW(TW)) u_horz (
    .clk    (clk),
    .rst    (rst),
    .clear  (stat.restart),
    .step   (adv),
    .src    (h_src),
    .dst    (h_dst),
    .base   (h_base),
    .period (h_period),
    .mode   (h_mode),
    .last   (h_last),
    .copies (h_copies)
  );

  plrs_axis #(.SW(SW), .TW(TW)) u_vert (
    .clk    (clk),
    .rst    (rst),
    .clear  (stat.restart),
    .step   (adv && h_last),
    .src    (v_src),
    .dst    (v_dst),
    .base   (v_base),
    .period (v_period),
    .mode   (v_mode),
    .last   (v_last),
    .copies (v_copies)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) s1_valid <= 1'b1;
      else if (adv) s1_valid <= 1'b0;
      if (adv) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_pixel <= pixel;
    if (adv) begin
      pixel_out    <= s1_pixel;
      pixel_copies <= COUNT_OUT_W'(h_copies);
      row_copies   <= COUNT_OUT_W'(v_copies);
      end_of_row   <= h_last;
      end_of_frame <= h_last && v_last;
    end
  end

`ifndef SYNTHESIS
  a_frame_ends_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!end_of_frame || end_of_row))
    else $error("end of frame without end of row");

  a_write_blocks_input: assert property (@(posedge clk) disable iff (rst)
    stat.restart |=> !in_ready && !cfg_ready)
    else $error("input open during derivation");

  a_busy_from_write: assert property (@(posedge clk) disable iff (rst)
    $rose(stat.busy) |-> $past(stat.restart))
    else $error("derivation started without a write");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(s1_pixel))
    else $error("held pixel lost");
`endif

endmodule
`default_nettype wire
